/* design/pss_pkg.sv */
// pss_pkg: shared types and constants of the pad step sequencer
// depends on nothing; used by pad_step_sequencer
package pss_pkg;

  // action codes carried in s_tuser
  typedef enum logic [3:0] {
    ACT_TICK        = 4'd0,
    ACT_TOGGLE_CELL = 4'd1,
    ACT_TOGGLE_PAR  = 4'd2,
    ACT_START_STOP  = 4'd3,
    ACT_RENDER      = 4'd4,
    ACT_SCRUB       = 4'd5,
    ACT_REWIND      = 4'd6,
    ACT_CLEAR_ROW   = 4'd7,
    ACT_SET_CELL    = 4'd8
  } action_t;

  // fixed field widths
  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned PAD_W     = 3;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned BARS_W    = 7;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned RENDER_W  = 11;
  localparam int unsigned BAR_SHIFT = 4;  // sixteen steps per bar

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  // one result item
  typedef struct packed {
    logic              stop_all;
    logic              is_playing;
    logic [POS_W-1:0]  position;
    logic              metronome_accent;
    logic              metronome_pulse;
    logic [MASK_W-1:0] trigger_mask;
  } result_t;

endpackage

/* design/pad_step_sequencer.sv */
// pad_step_sequencer: top level of the drum pad step sequencer
// depends on pss_pkg (action codes, field widths, result type)

// Drum step sequencer with a PAD_COUNT by STEP_COUNT grid of on/off cells
// held in flip-flops, one row register per pad. Every input transaction
// carries an action code in s_tuser: the action, the grid and the
// transport state go through one layer of logic and the result lands in
// the output register, or in the skid register while a result waits on
// m_tready, so one transaction is taken every cycle while s_tready is
// high. A skid register behind the output lets one more transaction
// enter while a result waits on m_tready; s_tready drops only while the
// skid register is full. Every input gives exactly one result transaction.
// The metronome enable register is written through cfg_write/cfg_data and
// should only be changed while no result is pending.
module pad_step_sequencer #(
  parameter int unsigned PAD_COUNT  = 8,
  parameter int unsigned STEP_COUNT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: metronome enable
  input  logic                            cfg_write,
  input  logic                            cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata: pad [2:0], step [8:3], bars [15:9]
  input  logic [pss_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: action [3:0]
  input  logic [pss_pkg::ACTION_W-1:0]    s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: trigger_mask [7:0], metronome_pulse [8], metronome_accent [9],
  //        position [15:10], is_playing [16], stop_all [17], zero [23:18]
  output logic [pss_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int unsigned PH_W = $clog2(STEP_COUNT);

  // unpacked input fields
  logic [pss_pkg::PAD_W-1:0]  pad;
  logic [pss_pkg::STEP_W-1:0] step;
  logic [pss_pkg::BARS_W-1:0] bars;
  pss_pkg::action_t           action;

  assign pad    = s_tdata[2:0];
  assign step   = s_tdata[8:3];
  assign bars   = s_tdata[15:9];
  assign action = pss_pkg::action_t'(s_tuser);

  // sequencer state
  logic [STEP_COUNT-1:0]         grid [PAD_COUNT];
  logic [PH_W-1:0]               playhead;
  logic                          running;
  logic                          render_active;
  logic [pss_pkg::RENDER_W-1:0]  render_count;
  logic [pss_pkg::RENDER_W-1:0]  render_total;
  logic                          metronome_enable;

  logic [STEP_COUNT-1:0]         grid_next [PAD_COUNT];
  logic [PH_W-1:0]               playhead_next;
  logic                          running_next;
  logic                          render_active_next;
  logic [pss_pkg::RENDER_W-1:0]  render_count_next;
  logic [pss_pkg::RENDER_W-1:0]  render_total_next;

  // output register and skid register
  logic                          out_valid;
  pss_pkg::result_t              out_data;
  logic                          skid_valid;
  pss_pkg::result_t              skid_data;

  logic                          accept;
  logic                          taken;

  // per-item decode
  logic                          cell_ok;
  logic                          pad_ok;
  logic                          step_ok;
  logic [PH_W-1:0]               col_idx;
  logic [PH_W-1:0]               scrub_target;
  logic [PH_W-1:0]               ph_inc;
  logic [pss_pkg::RENDER_W-1:0]  count_inc;
  logic                          do_fire;
  logic                          stop_req;
  logic [STEP_COUNT-1:0]         parity_mask;

  // firing column and result assembly
  logic [PAD_COUNT-1:0]          fire_col;
  logic [PAD_COUNT+7:0]          fire_col_ext;
  logic [PH_W+5:0]               ph_ext;
  pss_pkg::result_t              result;

  assign accept   = s_tvalid && s_tready;
  assign taken    = out_valid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(pss_pkg::OUT_DATA_W - $bits(pss_pkg::result_t)){1'b0}}, out_data};

  // range checks on pad and step
  assign pad_ok  = int'(pad) < PAD_COUNT;
  assign step_ok = int'(step) < STEP_COUNT;
  assign cell_ok = pad_ok && step_ok;
  // only used when step is in range, so truncation is safe
  assign col_idx = PH_W'(step);

  // scrub target saturates at the last step
  assign scrub_target = step_ok ? PH_W'(step) : PH_W'(STEP_COUNT - 1);

  // playhead advance wraps at the grid length
  assign ph_inc    = (int'(playhead) == STEP_COUNT - 1) ? '0 : playhead + PH_W'(1);
  assign count_inc = render_count + pss_pkg::RENDER_W'(1);

  // steps sharing the clicked step's parity
  always_comb begin
    for (int i = 0; i < STEP_COUNT; i++) begin
      parity_mask[i] = (i % 2) == int'(step[0]);
    end
  end

  // transport: playhead, running flag and render bookkeeping
  always_comb begin
    playhead_next      = playhead;
    running_next       = running;
    render_active_next = render_active;
    render_count_next  = render_count;
    render_total_next  = render_total;
    do_fire            = 1'b0;
    stop_req           = 1'b0;
    case (action)
      pss_pkg::ACT_TICK: begin
        if (running) begin
          playhead_next = ph_inc;
          do_fire       = 1'b1;
          if (render_active) begin
            render_count_next = count_inc;
            // render run is over once the advance count meets the total
            if (count_inc >= render_total) begin
              render_active_next = 1'b0;
              running_next       = 1'b0;
              stop_req           = 1'b1;
            end
          end
        end
      end
      pss_pkg::ACT_START_STOP: begin
        if (running) begin
          running_next = 1'b0;
          stop_req     = 1'b1;
        end else begin
          running_next  = 1'b1;
          playhead_next = '0;
          do_fire       = 1'b1;
        end
      end
      pss_pkg::ACT_RENDER: begin
        // zero bars leaves everything as it is
        if (bars != '0) begin
          render_active_next = 1'b1;
          render_total_next  = {bars, {pss_pkg::BAR_SHIFT{1'b0}}};
          render_count_next  = '0;
          running_next       = 1'b1;
          playhead_next      = '0;
          do_fire            = 1'b1;
        end
      end
      pss_pkg::ACT_SCRUB: begin
        playhead_next = scrub_target;
        do_fire       = running;
      end
      pss_pkg::ACT_REWIND: begin
        playhead_next = '0;
      end
      default: begin
      end
    endcase
  end

  // grid edits: each pad row updates itself when it is the addressed row
  always_comb begin
    for (int p = 0; p < PAD_COUNT; p++) begin
      grid_next[p] = grid[p];
      if (int'(pad) == p) begin
        case (action)
          pss_pkg::ACT_TOGGLE_CELL: begin
            if (cell_ok) begin
              grid_next[p][col_idx] = !grid[p][col_idx];
            end
          end
          pss_pkg::ACT_TOGGLE_PAR: begin
            // same-parity cells all take the inverse of the clicked cell
            if (cell_ok) begin
              if (grid[p][col_idx]) begin
                grid_next[p] = grid[p] & ~parity_mask;
              end else begin
                grid_next[p] = grid[p] | parity_mask;
              end
            end
          end
          pss_pkg::ACT_CLEAR_ROW: begin
            grid_next[p] = '0;
          end
          pss_pkg::ACT_SET_CELL: begin
            if (cell_ok) begin
              grid_next[p][col_idx] = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // column of the step that fires, read from the grid before any edit
  always_comb begin
    for (int p = 0; p < PAD_COUNT; p++) begin
      fire_col[p] = grid[p][playhead_next];
    end
  end

  // only the low eight pads are visible in the trigger mask
  assign fire_col_ext = {8'b0, fire_col};
  assign ph_ext       = {6'b0, playhead_next};

  always_comb begin
    result                  = '0;
    result.position         = ph_ext[pss_pkg::POS_W-1:0];
    result.is_playing       = running_next;
    result.stop_all         = stop_req;
    if (do_fire) begin
      result.trigger_mask = fire_col_ext[pss_pkg::MASK_W-1:0];
      // click every fourth step, accented every sixteenth
      if (metronome_enable && (playhead_next[1:0] == 2'b00)) begin
        result.metronome_pulse  = 1'b1;
        result.metronome_accent = (playhead_next[3:0] == 4'b0000);
      end
    end
  end

  // state registers, written on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        grid[p] <= '0;
      end
      playhead      <= '0;
      running       <= 1'b0;
      render_active <= 1'b0;
      render_count  <= '0;
      render_total  <= '0;
    end else if (accept) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        grid[p] <= grid_next[p];
      end
      playhead      <= playhead_next;
      running       <= running_next;
      render_active <= render_active_next;
      render_count  <= render_count_next;
      render_total  <= render_total_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      metronome_enable <= 1'b0;
    end else if (cfg_write) begin
      metronome_enable <= cfg_data;
    end
  end

  // output register with skid: a result that cannot move on parks in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || taken) begin
        out_valid  <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || taken) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule
